// ===== sv/ctg_pkg.sv =====
package ctg_pkg;

    // Component masks of the four Tausworthe steps.
    localparam logic [31:0] MASK_ONE   = 32'hFFFF_FFFE;
    localparam logic [31:0] MASK_TWO   = 32'hFFFF_FFF8;
    localparam logic [31:0] MASK_THREE = 32'hFFFF_FFF0;
    localparam logic [31:0] MASK_FOUR  = 32'hFFFF_FF80;

    // Seed value after reset.
    localparam logic [31:0] SEED_RESET = 32'h0000_0001;

    // Operation codes of an input beat.
    localparam logic OP_RAW     = 1'b0;
    localparam logic OP_BOUNDED = 1'b1;

    // One drawn word with its request, passed from front to back.
    typedef struct packed {
        logic        op;
        logic [30:0] bound;
        logic [31:0] word;
    } ctg_entry_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        CTG_IDLE,
        CTG_DIV,
        CTG_OUT
    } ctg_state_t;

endpackage

// ===== sv/ctg_front.sv =====
module ctg_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [30:0]         s_bound,
    input  logic                q_full,
    output logic                q_push,
    output ctg_pkg::ctg_entry_t q_data
);

    logic [31:0] comp_one_reg, comp_two_reg, comp_three_reg, comp_four_reg;
    logic [31:0] comp_one_next, comp_two_next, comp_three_next, comp_four_next;
    logic [31:0] b_one, b_two, b_three, b_four;
    logic        accept;

    // Accept a beat whenever the queue has room.
    assign s_ready = ~q_full;
    assign accept  = s_valid & ~q_full;

    // One step of each component.
    always_comb begin
        b_one  = ((comp_one_reg << 6) ^ comp_one_reg) >> 13;
        comp_one_next = ((comp_one_reg & ctg_pkg::MASK_ONE) << 18) ^ b_one;
        b_two  = ((comp_two_reg << 2) ^ comp_two_reg) >> 27;
        comp_two_next = ((comp_two_reg & ctg_pkg::MASK_TWO) << 2) ^ b_two;
        b_three = ((comp_three_reg << 13) ^ comp_three_reg) >> 21;
        comp_three_next = ((comp_three_reg & ctg_pkg::MASK_THREE) << 7) ^ b_three;
        b_four = ((comp_four_reg << 3) ^ comp_four_reg) >> 12;
        comp_four_next = ((comp_four_reg & ctg_pkg::MASK_FOUR) << 13) ^ b_four;
    end

    // The drawn word goes to the queue with its request.
    assign q_push        = accept;
    assign q_data.op     = s_op;
    assign q_data.bound  = s_bound;
    assign q_data.word   = comp_one_next ^ comp_two_next ^ comp_three_next ^ comp_four_next;

    // Generator state: reloaded from the seed on reset and seed writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comp_one_reg   <= ctg_pkg::SEED_RESET;
            comp_two_reg   <= ctg_pkg::SEED_RESET << 10;
            comp_three_reg <= ctg_pkg::SEED_RESET << 20;
            comp_four_reg  <= ctg_pkg::SEED_RESET << 30;
        end else if (cfg_we) begin
            comp_one_reg   <= cfg_wdata;
            comp_two_reg   <= cfg_wdata << 10;
            comp_three_reg <= cfg_wdata << 20;
            comp_four_reg  <= cfg_wdata << 30;
        end else if (accept) begin
            comp_one_reg   <= comp_one_next;
            comp_two_reg   <= comp_two_next;
            comp_three_reg <= comp_three_next;
            comp_four_reg  <= comp_four_next;
        end
    end

endmodule

// ===== sv/ctg_queue.sv =====
module ctg_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ctg_pkg::ctg_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output ctg_pkg::ctg_entry_t pop_data,
    output logic                empty
);

    ctg_pkg::ctg_entry_t entry_reg [2];
    logic                wr_ptr_reg, rd_ptr_reg;
    logic [1:0]          count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== sv/ctg_back.sv =====
module ctg_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  ctg_pkg::ctg_entry_t q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [31:0]         m_value,
    output logic                m_bound_error
);

    ctg_pkg::ctg_state_t state_reg, state_next;
    logic [30:0] rem_reg, rem_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [30:0] bnd_reg, bnd_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] value_reg, value_next;
    logic        err_reg, err_next;
    logic [31:0] trial;
    logic [31:0] diff;

    assign m_valid       = (state_reg == ctg_pkg::CTG_OUT);
    assign m_value       = value_reg;
    assign m_bound_error = err_reg;

    // One remainder bit per cycle: shift in a dividend bit, subtract if it fits.
    assign trial = {rem_reg, dvd_reg[31]};
    assign diff  = trial - {1'b0, bnd_reg};

    // Next state and datapath control.
    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        bnd_next   = bnd_reg;
        cnt_next   = cnt_reg;
        value_next = value_reg;
        err_next   = err_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            ctg_pkg::CTG_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (q_data.op == ctg_pkg::OP_RAW) begin
                        value_next = q_data.word;
                        err_next   = 1'b0;
                        state_next = ctg_pkg::CTG_OUT;
                    end else if (q_data.bound == '0) begin
                        value_next = '0;
                        err_next   = 1'b1;
                        state_next = ctg_pkg::CTG_OUT;
                    end else begin
                        rem_next   = '0;
                        dvd_next   = q_data.word;
                        bnd_next   = q_data.bound;
                        cnt_next   = '0;
                        err_next   = 1'b0;
                        state_next = ctg_pkg::CTG_DIV;
                    end
                end
            end
            ctg_pkg::CTG_DIV: begin
                if (trial >= {1'b0, bnd_reg}) begin
                    rem_next = diff[30:0];
                end else begin
                    rem_next = trial[30:0];
                end
                dvd_next = {dvd_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    value_next = {1'b0, rem_next};
                    state_next = ctg_pkg::CTG_OUT;
                end
            end
            ctg_pkg::CTG_OUT: begin
                if (m_ready) begin
                    state_next = ctg_pkg::CTG_IDLE;
                end
            end
            default: state_next = ctg_pkg::CTG_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ctg_pkg::CTG_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        bnd_reg   <= bnd_next;
        cnt_reg   <= cnt_next;
        value_reg <= value_next;
        err_reg   <= err_next;
    end

endmodule

// ===== sv/combined_tausworthe_generator.sv =====
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------
// input    | s_valid / s_ready  | s_op (1), s_bound (31)
// result   | m_valid / m_ready  | m_value (32), m_bound_error (1)
// config   | cfg_we             | cfg_wdata (32), the seed
//
// A raw draw, or a bounded draw with bound zero, goes from the queue
// straight to the result register; a bounded draw first passes the remainder unit,
// which produces one remainder bit per cycle over the 32 word bits.
// The generator front accepts beats into a two-entry queue while the back
// end works, so input stalls only when that queue is full.
// Synchronous active-low reset loads the seed 1 and empties the queue.
module combined_tausworthe_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [30:0] s_bound,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value,
    output logic        m_bound_error
);

    ctg_pkg::ctg_entry_t push_data, pop_data;
    logic                push, pop, full, empty;

    // Generator front end.
    ctg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_bound   (s_bound),
        .q_full    (full),
        .q_push    (push),
        .q_data    (push_data)
    );

    // Decoupling queue.
    ctg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // Reduction back end and result register.
    ctg_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (empty),
        .q_data        (pop_data),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_bound_error (m_bound_error)
    );

endmodule

// ===== sv/ctg_checker.sv =====
module ctg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_value,
    input logic        m_bound_error
);

    // A stalled result beat stays valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_value) && $stable(m_bound_error))
        else $error("result payload changed while stalled");

    // A zero-bound error always carries a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bound_error |-> m_value == 32'd0)
        else $error("bound error with nonzero value");

    // Reset leaves no result pending and the input open.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

endmodule

bind combined_tausworthe_generator ctg_checker u_ctg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_value       (m_value),
    .m_bound_error (m_bound_error)
);
